// File: rtl/lcff_pkg.sv
`timescale 1ns / 1ps

package lcff_pkg;

  localparam int unsigned SLOT_W = 5;

  localparam logic [6:0]  PIXEL_COUNT_RST    = 7'd15;
  localparam logic [15:0] FRAME_INTERVAL_RST = 16'd25;
  localparam logic [15:0] ELAPSED_ONE        = 16'h0001;
  localparam logic [15:0] ELAPSED_MAX        = 16'hFFFF;
  localparam logic [31:0] PATTERN_ZERO       = 32'h0000_0000;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_HALF0 = 2'd2,
    REQ_HALF1 = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_FILLER = 2'd1,
    KIND_START  = 2'd2,
    KIND_STOP   = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    CFG_PIXEL_COUNT    = 1'b0,
    CFG_FRAME_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WR_CMP,
    ST_TICK_CHK,
    ST_PIX_ISSUE,
    ST_PIX_EMIT,
    ST_FILLER,
    ST_STOP
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  pixel_index;
    logic [31:0] color;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        half;
    logic [4:0]  slot;
    logic [31:0] pattern;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic  capture;
    logic  rd_idx;
    logic  wr_commit;
    logic  tick_inc;
    logic  slot_clr;
    logic  rd_cur;
    logic  emit;
    kind_e emit_kind;
    logic  emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       sending;
    logic       idx_ok;
    logic       cur_done;
    logic       cur_last;
    logic       slot_last;
    logic       reset_sent;
    logic       changed;
    logic       interval_met;
    logic       out_free;
  } sts_t;

endpackage

// File: rtl/lcff_ram.sv
`timescale 1ns / 1ps

module lcff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lcff_ctrl.sv
`timescale 1ns / 1ps

module lcff_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lcff_pkg::sts_t sts_i,
  output lcff_pkg::cmd_t cmd_o
);

  lcff_pkg::state_e state_q, state_d;
  logic             more_pix;
  logic             stop_due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcff_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign more_pix = !(sts_i.slot_last || sts_i.cur_last);
  assign stop_due = (sts_i.req == lcff_pkg::REQ_HALF1) && sts_i.reset_sent;

  always_comb begin
    state_d          = state_q;
    in_stall_o       = 1'b1;
    cmd_o            = '0;
    cmd_o.emit_kind  = lcff_pkg::KIND_PIXEL;
    case (state_q)
      lcff_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = lcff_pkg::ST_DECODE;
        end
      end
      lcff_pkg::ST_DECODE: begin
        case (sts_i.req)
          lcff_pkg::REQ_WRITE: begin
            if (sts_i.idx_ok) begin
              cmd_o.rd_idx = 1'b1;
              state_d      = lcff_pkg::ST_WR_CMP;
            end else begin
              state_d = lcff_pkg::ST_IDLE;
            end
          end
          lcff_pkg::REQ_TICK: begin
            if (sts_i.sending) begin
              state_d = lcff_pkg::ST_IDLE;
            end else begin
              cmd_o.tick_inc = 1'b1;
              state_d        = lcff_pkg::ST_TICK_CHK;
            end
          end
          default: begin
            if (!sts_i.sending) begin
              state_d = lcff_pkg::ST_IDLE;
            end else begin
              cmd_o.slot_clr = 1'b1;
              state_d = sts_i.cur_done ? lcff_pkg::ST_FILLER : lcff_pkg::ST_PIX_ISSUE;
            end
          end
        endcase
      end
      lcff_pkg::ST_WR_CMP: begin
        cmd_o.wr_commit = 1'b1;
        state_d         = lcff_pkg::ST_IDLE;
      end
      lcff_pkg::ST_TICK_CHK: begin
        if (sts_i.changed && sts_i.interval_met) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = lcff_pkg::KIND_START;
          cmd_o.emit_last = 1'b1;
          if (sts_i.out_free) begin
            state_d = lcff_pkg::ST_IDLE;
          end
        end else begin
          state_d = lcff_pkg::ST_IDLE;
        end
      end
      lcff_pkg::ST_PIX_ISSUE: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = lcff_pkg::ST_PIX_EMIT;
      end
      lcff_pkg::ST_PIX_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = lcff_pkg::KIND_PIXEL;
        cmd_o.emit_last = !more_pix && !stop_due;
        if (sts_i.out_free) begin
          if (more_pix) begin
            state_d = lcff_pkg::ST_PIX_ISSUE;
          end else if (stop_due) begin
            state_d = lcff_pkg::ST_STOP;
          end else begin
            state_d = lcff_pkg::ST_IDLE;
          end
        end
      end
      lcff_pkg::ST_FILLER: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = lcff_pkg::KIND_FILLER;
        cmd_o.emit_last = (sts_i.req != lcff_pkg::REQ_HALF1);
        if (sts_i.out_free) begin
          state_d = (sts_i.req == lcff_pkg::REQ_HALF1) ? lcff_pkg::ST_STOP
                                                       : lcff_pkg::ST_IDLE;
        end
      end
      lcff_pkg::ST_STOP: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = lcff_pkg::KIND_STOP;
        cmd_o.emit_last = 1'b1;
        if (sts_i.out_free) begin
          state_d = lcff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcff_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lcff_dp.sv
`timescale 1ns / 1ps

module lcff_dp #(
  parameter int unsigned MAX_PIXELS    = 64,
  parameter int unsigned LEDS_PER_HALF = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  lcff_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcff_pkg::out_item_t out_item_o,
  input  lcff_pkg::cmd_t      cmd_i,
  output lcff_pkg::sts_t      sts_o
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam logic [8:0] MaxPix9 = 9'(MAX_PIXELS);
  localparam logic [lcff_pkg::SLOT_W-1:0] SlotLast = lcff_pkg::SLOT_W'(LEDS_PER_HALF - 1);

  lcff_pkg::in_item_t  item_q;
  lcff_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;
  logic                out_free, emit_done;

  logic [6:0]          pixel_count_q;
  logic [15:0]         interval_q;
  logic [15:0]         elapsed_q;
  logic                sending_q, changed_q, reset_sent_q;
  logic [CW-1:0]       cursor_q;
  logic [lcff_pkg::SLOT_W-1:0] slot_q;
  logic [MAX_PIXELS-1:0] valid_q;
  logic                rd_valid_q;

  logic [8:0]          pc9, count9, idx9, cur9;
  logic [CW-1:0]       count;
  logic [CW:0]         cur_next;
  logic [AW-1:0]       idx_addr, cur_addr, ram_addr;
  logic                ram_re;
  logic [31:0]         ram_rdata, stored;

  assign pc9      = 9'(pixel_count_q);
  assign count9   = (pc9 > MaxPix9) ? MaxPix9 : pc9;
  assign count    = count9[CW-1:0];
  assign idx9     = 9'(item_q.pixel_index);
  assign cur9     = 9'(cursor_q);
  assign idx_addr = idx9[AW-1:0];
  assign cur_addr = cur9[AW-1:0];
  assign cur_next = (CW+1)'(cursor_q) + (CW+1)'(1);
  assign ram_addr = cmd_i.rd_cur ? cur_addr : idx_addr;
  assign ram_re   = cmd_i.rd_idx | cmd_i.rd_cur;
  assign stored   = rd_valid_q ? ram_rdata : lcff_pkg::PATTERN_ZERO;

  lcff_ram #(
    .WIDTH(32),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_commit),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(item_q.color),
    .rdata_o(ram_rdata)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_done = cmd_i.emit && out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (emit_done) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (ram_re) begin
      rd_valid_q <= valid_q[ram_addr];
    end
  end

  always_comb begin
    out_d         = '0;
    out_d.kind    = 2'(cmd_i.emit_kind);
    out_d.last    = cmd_i.emit_last;
    case (cmd_i.emit_kind)
      lcff_pkg::KIND_PIXEL: begin
        out_d.half    = item_q.req_type[0];
        out_d.slot    = slot_q;
        out_d.pattern = stored;
      end
      lcff_pkg::KIND_FILLER: begin
        out_d.half = item_q.req_type[0];
      end
      lcff_pkg::KIND_STOP: begin
        out_d.half = 1'b1;
      end
      default: begin
        out_d.half = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      pixel_count_q <= lcff_pkg::PIXEL_COUNT_RST;
      interval_q    <= lcff_pkg::FRAME_INTERVAL_RST;
      elapsed_q     <= '0;
      sending_q     <= 1'b0;
      changed_q     <= 1'b0;
      reset_sent_q  <= 1'b0;
      cursor_q      <= '0;
      slot_q        <= '0;
      valid_q       <= '0;
    end else begin
      if (emit_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          lcff_pkg::CFG_PIXEL_COUNT:    pixel_count_q <= cfg_wdata_i[6:0];
          lcff_pkg::CFG_FRAME_INTERVAL: interval_q    <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (cmd_i.wr_commit) begin
        valid_q[idx_addr] <= 1'b1;
        if (stored != item_q.color) begin
          changed_q <= 1'b1;
        end
      end

      if (cmd_i.tick_inc && (elapsed_q != lcff_pkg::ELAPSED_MAX)) begin
        elapsed_q <= elapsed_q + lcff_pkg::ELAPSED_ONE;
      end

      if (cmd_i.slot_clr) begin
        slot_q <= '0;
      end

      if (emit_done) begin
        case (cmd_i.emit_kind)
          lcff_pkg::KIND_START: begin
            sending_q    <= 1'b1;
            cursor_q     <= '0;
            changed_q    <= 1'b0;
            reset_sent_q <= 1'b0;
          end
          lcff_pkg::KIND_PIXEL: begin
            cursor_q <= cur_next[CW-1:0];
            slot_q   <= slot_q + lcff_pkg::SLOT_W'(1);
          end
          lcff_pkg::KIND_FILLER: begin
            reset_sent_q <= 1'b1;
          end
          lcff_pkg::KIND_STOP: begin
            sending_q <= 1'b0;
            elapsed_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sts_o              = '0;
    sts_o.req          = item_q.req_type;
    sts_o.sending      = sending_q;
    sts_o.idx_ok       = (idx9 < MaxPix9);
    sts_o.cur_done     = (cursor_q >= count);
    sts_o.cur_last     = (cur_next >= (CW+1)'(count));
    sts_o.slot_last    = (slot_q == SlotLast);
    sts_o.reset_sent   = reset_sent_q;
    sts_o.changed      = changed_q;
    sts_o.interval_met = (elapsed_q >= interval_q);
    sts_o.out_free     = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/led_chain_frame_feeder.sv
`timescale 1ns / 1ps

// Frame feeder for an addressable LED chain with a ping-pong half buffer.
// Input items (valid/stall) carry a pixel write, a millisecond tick or a
// "half drained" request; result items (valid/stall) carry pixel slots,
// reset fillers, frame start and frame stop, with last on the final one.
// The configuration port writes the pixel count and the frame interval.
// One item is worked on at a time; the input stalls until it is finished.
// A pixel write is decoded while the stored color is read from the pixel
// memory, then compared and written back. A tick counts the elapsed time
// and may then load a frame start. A buffer request loads one pixel slot
// at a time (memory read, then output load) up to a half, or a reset filler
// once all pixels are sent; a half-1 request then adds a frame stop.
// Results leave through a one-entry output register; while the receiver
// stalls, the current result holds and the block waits before loading the
// next one. A pixel write or tick may be accepted while a result still waits.
// Reset clears the control state, the written flags of the pixel memory (an
// unwritten pixel reads as zero) and loads the default configuration.
module led_chain_frame_feeder #(
  parameter int unsigned MAX_PIXELS    = 64,
  parameter int unsigned LEDS_PER_HALF = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcff_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcff_pkg::out_item_t out_item_o
);

  lcff_pkg::cmd_t cmd;
  lcff_pkg::sts_t sts;

  lcff_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lcff_dp #(
    .MAX_PIXELS   (MAX_PIXELS),
    .LEDS_PER_HALF(LEDS_PER_HALF)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// File: dv/frame_feeder_checker.sv
`timescale 1ns / 1ps

module frame_feeder_checker
  import lcff_pkg::*;
#(
  parameter int unsigned MAX_PIXELS    = 64,
  parameter int unsigned LEDS_PER_HALF = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int          owed_o,
  output int          fails_o
);

  logic [31:0] pixels [MAX_PIXELS];
  logic [6:0]  cursor;
  logic        busy;
  logic        changed;
  logic        filler_done;
  logic [15:0] idle_ms;
  logic [6:0]  led_count;
  logic [15:0] interval_ms;
  out_item_t   owed_items [$];
  int          fails = 0;

  function automatic out_item_t make_result(input kind_e kind, input logic half,
                                            input logic [4:0] slot,
                                            input logic [31:0] pattern);
    out_item_t r;
    r.kind    = kind;
    r.half    = half;
    r.slot    = slot;
    r.pattern = pattern;
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic advance_feeder(input in_item_t it);
    int unsigned first;
    int unsigned limit;
    int unsigned s;
    logic        half;
    out_item_t   tail;
    first = owed_items.size();
    case (req_e'(it.req_type))
      REQ_WRITE: begin
        if (pixels[it.pixel_index] != it.color) begin
          changed = 1'b1;
        end
        pixels[it.pixel_index] = it.color;
      end
      REQ_TICK: begin
        if (!busy) begin
          if (idle_ms != ELAPSED_MAX) begin
            idle_ms = idle_ms + ELAPSED_ONE;
          end
          if (changed && idle_ms >= interval_ms) begin
            busy        = 1'b1;
            cursor      = '0;
            changed     = 1'b0;
            filler_done = 1'b0;
            owed_items.push_back(make_result(KIND_START, 1'b0, 5'd0, PATTERN_ZERO));
          end
        end
      end
      default: begin
        if (busy) begin
          half  = (it.req_type == REQ_HALF1);
          limit = (led_count > MAX_PIXELS) ? MAX_PIXELS : led_count;
          if (cursor >= limit) begin
            owed_items.push_back(make_result(KIND_FILLER, half, 5'd0, PATTERN_ZERO));
            filler_done = 1'b1;
          end else begin
            s = 0;
            while (s < LEDS_PER_HALF && cursor < limit) begin
              owed_items.push_back(make_result(KIND_PIXEL, half, 5'(s),
                                               pixels[cursor % MAX_PIXELS]));
              cursor = cursor + 7'd1;
              s++;
            end
          end
          if (it.req_type == REQ_HALF1 && filler_done) begin
            owed_items.push_back(make_result(KIND_STOP, 1'b1, 5'd0, PATTERN_ZERO));
            busy    = 1'b0;
            idle_ms = '0;
          end
        end
      end
    endcase
    if (owed_items.size() > first) begin
      tail      = owed_items.pop_back();
      tail.last = 1'b1;
      owed_items.push_back(tail);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (owed_items.size() == 0) begin
      fails++;
      $display("%0t: unexpected result, expected none, got kind %0d half %0d slot %0d",
               $time, got.kind, got.half, got.slot,
               " pattern %08h last %0d", got.pattern, got.last);
    end else begin
      want = owed_items.pop_front();
      if (got.kind !== want.kind || got.half !== want.half || got.slot !== want.slot ||
          got.pattern !== want.pattern || got.last !== want.last) begin
        fails++;
        $display("%0t: result mismatch, expected kind %0d half %0d slot %0d",
                 $time, want.kind, want.half, want.slot,
                 " pattern %08h last %0d", want.pattern, want.last);
        $display("%0t: result mismatch, actual   kind %0d half %0d slot %0d",
                 $time, got.kind, got.half, got.slot,
                 " pattern %08h last %0d", got.pattern, got.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXELS; i++) begin
        pixels[i] = '0;
      end
      cursor      = '0;
      busy        = 1'b0;
      changed     = 1'b0;
      filler_done = 1'b0;
      idle_ms     = '0;
      led_count   = PIXEL_COUNT_RST;
      interval_ms = FRAME_INTERVAL_RST;
      owed_items.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_result(out_item_i);
      end
      if (in_valid_i && !in_stall_i) begin
        advance_feeder(in_item_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PIXEL_COUNT:    led_count   = cfg_wdata_i[6:0];
          CFG_FRAME_INTERVAL: interval_ms = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    owed_o  <= owed_items.size();
    fails_o <= fails;
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import lcff_pkg::*;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_idx_i   = CFG_PIXEL_COUNT;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  bit          gaps_on     = 1'b0;
  bit          stalls_on   = 1'b0;
  int unsigned stall_left  = 0;
  int          owed;
  int          fails;
  int unsigned sent        = 0;
  logic [6:0]  cur_count   = PIXEL_COUNT_RST;
  logic [15:0] cur_interval = FRAME_INTERVAL_RST;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  led_chain_frame_feeder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  frame_feeder_checker feed_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .owed_o      (owed),
    .fails_o     (fails)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (!stalls_on) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push(input req_e req, input logic [5:0] idx, input logic [31:0] col);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= {req, idx, col};
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic noise();
    push(req_e'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), $urandom());
  endtask

  task automatic rest();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [6:0] count, input logic [15:0] interval);
    rest();
    set_reg(CFG_PIXEL_COUNT, {9'd0, count});
    set_reg(CFG_FRAME_INTERVAL, interval);
    cur_count    = count;
    cur_interval = interval;
  endtask

  function automatic int unsigned halves_needed();
    int unsigned leds;
    leds = (cur_count > 64) ? 64 : cur_count;
    return (leds + 3) / 4 + 2;
  endfunction

  task automatic close_frame();
    repeat (halves_needed()) push(REQ_HALF1, 6'($urandom_range(0, 63)), $urandom());
  endtask

  task automatic run_frame();
    logic [5:0]  idx;
    logic [31:0] col;
    int unsigned halves;
    repeat ($urandom_range(1, 4)) begin
      idx = 6'($urandom_range(0, 63));
      col = $urandom();
      push(REQ_WRITE, idx, col);
      if ($urandom_range(0, 3) == 0) begin
        push(REQ_WRITE, idx, col);
      end
    end
    repeat (cur_interval + $urandom_range(1, 2)) begin
      push(REQ_TICK, 6'($urandom_range(0, 63)), $urandom());
    end
    halves = halves_needed();
    for (int unsigned i = 0; i < halves; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        noise();
      end
      push((i % 2 == 1) ? REQ_HALF1 : REQ_HALF0, 6'($urandom_range(0, 63)), $urandom());
    end
  endtask

  task automatic start_single_frame();
    logic [5:0]  idx;
    logic [31:0] col;
    idx = 6'($urandom_range(0, 63));
    col = $urandom();
    push(REQ_WRITE, idx, col);
    push(REQ_WRITE, idx, ~col);
    push(REQ_TICK, 6'd0, 32'd0);
  endtask

  initial begin
    int unsigned base;
    int unsigned fin;
    int unsigned pick;
    bit          quiet;
    logic [6:0]  count;
    logic [15:0] interval;

    repeat (2) @(posedge clk_i);
    rst_ni    <= 1'b1;
    gaps_on   <= 1'b1;
    stalls_on <= 1'b1;
    @(posedge clk_i);

    push(REQ_HALF0, 6'd0, 32'd0);
    push(REQ_HALF1, 6'd63, 32'hFFFF_FFFF);
    push(REQ_TICK, 6'd0, 32'd0);
    push(REQ_WRITE, 6'd5, 32'd0);
    push(REQ_TICK, 6'd0, 32'd0);
    push(REQ_WRITE, 6'd0, 32'hFFFF_FFFF);
    push(REQ_WRITE, 6'd63, 32'h8000_0001);
    push(REQ_WRITE, 6'd1, 32'h1234_5678);
    push(REQ_TICK, 6'd0, 32'd0);
    configure(7'd5, 16'd0);
    push(REQ_TICK, 6'd0, 32'd0);
    push(REQ_TICK, 6'd0, 32'd0);
    push(REQ_WRITE, 6'd2, 32'hA5A5_5A5A);
    push(REQ_HALF0, 6'd0, 32'd0);
    push(REQ_HALF1, 6'd0, 32'd0);
    push(REQ_HALF0, 6'd0, 32'd0);
    push(REQ_HALF1, 6'd0, 32'd0);
    push(REQ_HALF0, 6'd0, 32'd0);
    configure(7'd0, 16'd1);
    push(REQ_TICK, 6'd0, 32'd0);
    push(REQ_HALF1, 6'd0, 32'd0);

    configure(7'd1, 16'd0);
    start_single_frame();
    push(REQ_HALF1, 6'd0, 32'd0);
    push(REQ_HALF1, 6'd0, 32'd0);

    base = sent;
    for (int p = 0; sent - base < 350; p++) begin
      close_frame();
      case (p)
        0: configure(7'd127, 16'd0);
        1: configure(7'd1, 16'd1);
        2: configure(7'd64, 16'd2);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            count = 7'd0;
          end else if (pick == 1) begin
            count = 7'($urandom_range(64, 127));
          end else begin
            count = 7'($urandom_range(1, 16));
          end
          if ($urandom_range(0, 7) == 0) begin
            interval = 16'($urandom_range(8, 40));
          end else begin
            interval = 16'($urandom_range(0, 4));
          end
          configure(count, interval);
        end
      endcase
      quiet = (sent - base >= 300);
      if (quiet) begin
        gaps_on   <= 1'b0;
        stalls_on <= 1'b0;
      end else begin
        gaps_on   <= ($urandom_range(0, 3) != 0);
        stalls_on <= ($urandom_range(0, 3) != 0);
      end
      fin = sent + 35;
      while (sent < fin && (quiet || sent - base < 300) && sent - base < 350) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          run_frame();
        end else if (pick < 9) begin
          noise();
        end else begin
          rest();
        end
      end
    end
    close_frame();
    rest();

    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
